FILE: rtl/tcd_pkg.sv
package tcd_pkg;

  // Field widths
  localparam int PIXEL_W     = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int ROW_W       = 12;

  // Register indexes on the config channel
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD    = 2'd2;

  // Register reset values
  localparam int RST_IMAGE_WIDTH  = 640;
  localparam int RST_IMAGE_HEIGHT = 480;
  localparam int RST_THRESHOLD    = 127;

  // Smallest legal frame edge
  localparam int MIN_EDGE = 3;

  // Output levels
  localparam logic [PIXEL_W-1:0] DARK_LEVEL  = 8'd0;
  localparam logic [PIXEL_W-1:0] WHITE_LEVEL = 8'd255;

  // One result word
  typedef struct packed {
    logic [PIXEL_W-1:0] out_pixel;
    logic               frame_last;
  } result_t;

endpackage

FILE: rtl/tcd_if.sv
// Pixel input channel
interface tcd_pix_if;
  logic                        valid;
  logic                        ready;
  logic [tcd_pkg::PIXEL_W-1:0] gray_pixel;
  logic                        flush;

  modport source (output valid, output gray_pixel, output flush, input ready);
  modport sink   (input valid, input gray_pixel, input flush, output ready);
endinterface

// Result output channel
interface tcd_res_if;
  logic                        valid;
  logic                        ready;
  logic [tcd_pkg::PIXEL_W-1:0] out_pixel;
  logic                        frame_last;

  modport source (output valid, output out_pixel, output frame_last, input ready);
  modport sink   (input valid, input out_pixel, input frame_last, output ready);
endinterface

// Register write channel
interface tcd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tcd_pkg::CFG_INDEX_W-1:0] index;
  logic [tcd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/threshold_cross_dilation.sv
// Thresholded 3x3 cross dilation over a raster pixel stream.
// Throughput: one word per clock while the output buffer has room; the two line stores
// sit in RAMs read every cycle at the upcoming column and the one after it, so no item
// waits on a memory port. Output runs one image row behind the input, the final row
// driven by flush words.
// Reset: counters and output buffer clear, registers return to 640 x 480, threshold 127.
module threshold_cross_dilation #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic      clk,
  input  logic      rst,
  tcd_pix_if.sink   pixels,
  tcd_res_if.source results,
  tcd_cfg_if.sink   cfg
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int XW = WW + 1;
  localparam int RW = tcd_pkg::ROW_W;
  localparam int WIDTH_RST = (tcd_pkg::RST_IMAGE_WIDTH > MAX_WIDTH) ?
                             MAX_WIDTH : tcd_pkg::RST_IMAGE_WIDTH;

  // Registers (width and height held already clamped)
  logic [WW-1:0]               width_eff;
  logic [RW-1:0]               height_eff;
  logic [tcd_pkg::PIXEL_W-1:0] threshold;

  // Raster position
  logic [AW-1:0] col, col_next;
  logic [RW-1:0] row, row_next;
  logic          left_bit, left_bit_next;

  // Line store RAMs: A holds {row-2, row-1} at col, B holds row-1 at col+1
  logic [1:0]    ram_a_q;
  logic [0:0]    ram_b_q;
  logic [1:0]    ram_a_wdata;
  logic [AW-1:0] raddr_a, raddr_b;

  logic             accept, act, final_phase, row_end, emit;
  logic             cur, mid, up, right, dark;
  logic [XW-1:0]    x, w;
  logic [RW:0]      r, h;
  logic             buf_room;
  tcd_pkg::result_t res_word;

  // Config writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= WW'(WIDTH_RST);
      height_eff <= RW'(tcd_pkg::RST_IMAGE_HEIGHT);
      threshold  <= tcd_pkg::PIXEL_W'(tcd_pkg::RST_THRESHOLD);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        tcd_pkg::REG_IMAGE_WIDTH: begin
          if (int'(cfg.data) < tcd_pkg::MIN_EDGE) begin
            width_eff <= WW'(tcd_pkg::MIN_EDGE);
          end else if (int'(cfg.data) > MAX_WIDTH) begin
            width_eff <= WW'(MAX_WIDTH);
          end else begin
            width_eff <= WW'(cfg.data);
          end
        end
        tcd_pkg::REG_IMAGE_HEIGHT: begin
          if (int'(cfg.data) < tcd_pkg::MIN_EDGE) begin
            height_eff <= RW'(tcd_pkg::MIN_EDGE);
          end else begin
            height_eff <= RW'(cfg.data);
          end
        end
        tcd_pkg::REG_THRESHOLD: begin
          threshold <= cfg.data[tcd_pkg::PIXEL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Handshake and phase
  assign pixels.ready = buf_room;
  assign accept       = pixels.valid & pixels.ready;
  assign final_phase  = row >= height_eff;
  assign act          = accept & (pixels.flush == final_phase);

  // Widened copies for the border compares
  assign x = XW'(col);
  assign w = XW'(width_eff);
  assign r = (RW + 1)'(row);
  assign h = (RW + 1)'(height_eff);

  // Neighborhood
  assign cur   = ~pixels.flush & (pixels.gray_pixel <= threshold);
  assign mid   = ram_a_q[0];
  assign up    = ram_a_q[1];
  assign right = ram_b_q[0];

  // Dark if self dark, or an interior cross neighbor is dark
  always_comb begin
    dark = mid;
    if (left_bit && x >= XW'(2) && r >= (RW + 1)'(2) && r < h) begin
      dark = 1'b1;
    end
    if (right && x + XW'(2) < w && r >= (RW + 1)'(2) && r < h) begin
      dark = 1'b1;
    end
    if (up && x >= XW'(1) && x + XW'(1) < w && r >= (RW + 1)'(3) && r <= h) begin
      dark = 1'b1;
    end
    if (cur && x >= XW'(1) && x + XW'(1) < w && r + (RW + 1)'(1) < h) begin
      dark = 1'b1;
    end
  end

  // Position update
  assign row_end = (x + XW'(1)) >= w;

  always_comb begin
    col_next      = col;
    row_next      = row;
    left_bit_next = left_bit;
    if (act) begin
      if (row_end) begin
        col_next      = '0;
        left_bit_next = 1'b0;
        row_next      = final_phase ? '0 : row + RW'(1);
      end else begin
        col_next      = col + AW'(1);
        left_bit_next = mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      left_bit <= 1'b0;
    end else begin
      col      <= col_next;
      row      <= row_next;
      left_bit <= left_bit_next;
    end
  end

  // Read addresses track the next position; data is ready when that position is current
  always_comb begin
    raddr_a = rst ? '0 : col_next;
    if (32'(raddr_a) + 1 >= MAX_WIDTH) begin
      raddr_b = '0;
    end else begin
      raddr_b = raddr_a + AW'(1);
    end
  end

  assign ram_a_wdata = {mid, cur};

  tcd_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (act),
    .waddr (col),
    .wdata (ram_a_wdata),
    .raddr (raddr_a),
    .rdata (ram_a_q)
  );

  tcd_ram #(
    .WIDTH (1),
    .DEPTH (MAX_WIDTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (act),
    .waddr (col),
    .wdata (cur),
    .raddr (raddr_b),
    .rdata (ram_b_q)
  );

  // Result word
  assign emit                = act & (row != '0);
  assign res_word.out_pixel  = dark ? tcd_pkg::DARK_LEVEL : tcd_pkg::WHITE_LEVEL;
  assign res_word.frame_last = final_phase & row_end;

  tcd_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_word (res_word),
    .has_room  (buf_room),
    .res       (results)
  );

endmodule

FILE: rtl/tcd_ram.sv
// Simple dual-port RAM: one write port, one registered read port
module tcd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/tcd_outbuf.sv
// Two-word output buffer: head register plus skid register
module tcd_outbuf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tcd_pkg::result_t push_word,
  output logic             has_room,
  tcd_res_if.source        res
);

  tcd_pkg::result_t head;
  tcd_pkg::result_t skid;
  logic             head_valid;
  logic             skid_valid;
  logic             pop;

  assign pop            = head_valid & res.ready;
  assign has_room       = ~skid_valid;
  assign res.valid      = head_valid;
  assign res.out_pixel  = head.out_pixel;
  assign res.frame_last = head.frame_last;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= push;
      end else begin
        head_valid <= push;
      end
    end else if (push) begin
      if (head_valid) begin
        skid_valid <= 1'b1;
      end else begin
        head_valid <= 1'b1;
      end
    end
  end

  // Data
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        head <= skid;
        if (push) begin
          skid <= push_word;
        end
      end else if (push) begin
        head <= push_word;
      end
    end else if (push) begin
      if (head_valid) begin
        skid <= push_word;
      end else begin
        head <= push_word;
      end
    end
  end

endmodule
